### rtl/gcmenc_pkg.sv
`timescale 1ns / 1ps

package gcmenc_pkg;

   typedef enum logic [1:0] {
      CMD_START  = 2'd0,
      CMD_AAD    = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_FINISH = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_KEYEXP,
      ST_AES,
      ST_GHASH
   } state_type;

   // what the running block cipher pass is for
   typedef enum logic [1:0] {
      JOB_HSUB,
      JOB_TMASK,
      JOB_TEXT
   } job_type;

   localparam logic [2:0] CSR_KEY_HI = 3'd0;
   localparam logic [2:0] CSR_KEY_LO = 3'd1;
   localparam logic [2:0] CSR_IV_HI  = 3'd2;
   localparam logic [2:0] CSR_IV_LO  = 3'd3;

   localparam int unsigned NUM_ROUNDS = 10;
   localparam int unsigned GF_BITS_PER_CYCLE = 8;

   localparam logic [127:0] GF_REDUCE = {8'hE1, 120'd0};

   // classified request as queued between front and back
   typedef struct packed {
      cmd_type      cmd;
      logic [127:0] data;
      logic [127:0] mask;
      logic [7:0]   nbits;
   } item_type;

   typedef struct packed {
      logic         valid;
      logic [127:0] value;
      logic         is_tag;
   } result_type;

   typedef struct packed {
      logic [127:0] z;
      logic [127:0] v;
   } gf_type;

   localparam logic [7:0] RCON [10] = '{
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // one AES round; byte 0 sits in the top bits, byte i is row i%4 of column i/4
   function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                              input logic last);
      logic [7:0]   sb [16];
      logic [7:0]   t  [16];
      logic [7:0]   m  [16];
      logic [7:0]   a0, a1, a2, a3;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         sb[i] = SBOX[s[127 - 8 * i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4 * c] = sb[i + 4 * ((c + i) & 3)];
         end
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c];
         a1 = t[4 * c + 1];
         a2 = t[4 * c + 2];
         a3 = t[4 * c + 3];
         m[4 * c]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         m[4 * c + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         m[4 * c + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         m[4 * c + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8 * i -: 8] = (last ? t[i] : m[i]) ^ rk[127 - 8 * i -: 8];
      end
      aes_round = r;
   endfunction

   function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, rot, t, n0, n1, n2, n3;
      w0  = rk[127:96];
      w1  = rk[95:64];
      w2  = rk[63:32];
      w3  = rk[31:0];
      rot = {w3[23:0], w3[31:24]};
      t   = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]}
            ^ {rc, 24'd0};
      n0  = w0 ^ t;
      n1  = w1 ^ n0;
      n2  = w2 ^ n1;
      n3  = w3 ^ n2;
      key_next = {n0, n1, n2, n3};
   endfunction

   // eight bits of the GF(2^128) shift-and-add product, MSB of x first
   function automatic gf_type gf_step(input gf_type g, input logic [7:0] x);
      gf_type r;
      logic   lsb;
      r = g;
      for (int i = 0; i < GF_BITS_PER_CYCLE; i++) begin
         if (x[7 - i]) begin
            r.z = r.z ^ r.v;
         end
         lsb = r.v[0];
         r.v = {1'b0, r.v[127:1]} ^ (lsb ? GF_REDUCE : 128'd0);
      end
      gf_step = r;
   endfunction

endpackage

### rtl/gcmenc_front.sv
`timescale 1ns / 1ps

module gcmenc_front import gcmenc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_cmd,
   input  logic [63:0]   req_data_hi,
   input  logic [63:0]   req_data_lo,
   input  logic [4:0]    req_valid_bytes,
   output logic          q_valid,
   output item_type      q_item,
   input  logic          q_pop
);

   item_type    fifo_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push;
   logic        pop;
   logic [4:0]  nsat;
   logic [127:0] mask;
   item_type    item;

   // saturate byte count, build byte mask, zero the padding
   always_comb begin
      nsat = (req_valid_bytes > 5'd16) ? 5'd16 : req_valid_bytes;
      for (int k = 0; k < 16; k++) begin
         mask[127 - 8 * k -: 8] = (5'(k) < nsat) ? 8'hff : 8'h00;
      end
      item.cmd   = cmd_type'(req_cmd);
      item.data  = {req_data_hi, req_data_lo} & mask;
      item.mask  = mask;
      item.nbits = {nsat, 3'd0};
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = fifo_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

### rtl/gcmenc_back.sv
`timescale 1ns / 1ps

module gcmenc_back import gcmenc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  item_type      q_item,
   output logic          q_pop,
   input  logic [127:0]  key,
   input  logic [95:0]   iv,
   input  logic          out_busy,
   output result_type    result
);

   state_type    state_ff, state_in;
   job_type      job_ff, job_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [3:0]   gcnt_ff, gcnt_in;
   logic [127:0] rk_ff [11];
   logic         rk_we;
   logic [3:0]   rk_waddr;
   logic [127:0] rk_wdata;
   logic [127:0] prev_ff, prev_in;
   logic [127:0] aes_ff, aes_in;
   logic [127:0] hsub_ff, hsub_in;
   logic [127:0] tmask_ff, tmask_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  ctr_ff, ctr_in;
   logic [63:0]  aad_bits_ff, aad_bits_in;
   logic [63:0]  text_bits_ff, text_bits_in;
   logic [127:0] x_ff, x_in;
   gf_type       gf_ff, gf_in;
   logic [127:0] ct_ff, ct_in;
   logic [127:0] data_ff, data_in;
   logic [127:0] mask_ff, mask_in;
   logic         tag_ff, tag_in;
   logic         emit_ff, emit_in;

   logic         take;
   logic [127:0] rk_cur;
   logic [127:0] round_out;
   logic [127:0] key_new;
   logic [127:0] ct_new;
   gf_type       gf_new;
   logic         aes_last;
   logic         gf_last;

   assign rk_cur    = rk_ff[rnd_ff];
   assign aes_last  = (rnd_ff == 4'(NUM_ROUNDS));
   assign round_out = aes_round(aes_ff, rk_cur, aes_last);
   assign key_new   = key_next(prev_ff, RCON[rnd_ff - 4'd1]);
   assign ct_new    = (data_ff ^ round_out) & mask_ff;
   assign gf_new    = gf_step(gf_ff, x_ff[127:120]);
   assign gf_last   = (gcnt_ff == 4'd15);
   assign take      = (state_ff == ST_IDLE) && q_valid && !out_busy;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               unique case (q_item.cmd) inside
                  CMD_START:              state_in = ST_KEYEXP;
                  CMD_TEXT:               state_in = ST_AES;
                  CMD_AAD, CMD_FINISH:    state_in = ST_GHASH;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_KEYEXP: begin
            if (aes_last) state_in = ST_AES;
         end
         ST_AES: begin
            if (aes_last) begin
               unique case (job_ff)
                  JOB_HSUB:  state_in = ST_AES;
                  JOB_TMASK: state_in = ST_IDLE;
                  JOB_TEXT:  state_in = ST_GHASH;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_GHASH: begin
            if (gf_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      q_pop        = take;
      job_in       = job_ff;
      rnd_in       = rnd_ff;
      gcnt_in      = gcnt_ff;
      rk_we        = 1'b0;
      rk_waddr     = rnd_ff;
      rk_wdata     = key_new;
      prev_in      = prev_ff;
      aes_in       = aes_ff;
      hsub_in      = hsub_ff;
      tmask_in     = tmask_ff;
      acc_in       = acc_ff;
      ctr_in       = ctr_ff;
      aad_bits_in  = aad_bits_ff;
      text_bits_in = text_bits_ff;
      x_in         = x_ff;
      gf_in        = gf_ff;
      ct_in        = ct_ff;
      data_in      = data_ff;
      mask_in      = mask_ff;
      tag_in       = tag_ff;
      emit_in      = emit_ff;
      result.valid  = 1'b0;
      result.value  = ct_ff;
      result.is_tag = tag_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               data_in = q_item.data;
               mask_in = q_item.mask;
               gcnt_in = 4'd0;
               gf_in.z = 128'd0;
               gf_in.v = hsub_ff;
               rnd_in  = 4'd1;
               unique case (q_item.cmd)
                  CMD_START: begin
                     rk_we        = 1'b1;
                     rk_waddr     = 4'd0;
                     rk_wdata     = key;
                     prev_in      = key;
                     acc_in       = 128'd0;
                     ctr_in       = 32'd1;
                     aad_bits_in  = 64'd0;
                     text_bits_in = 64'd0;
                  end
                  CMD_AAD: begin
                     x_in        = acc_ff ^ q_item.data;
                     aad_bits_in = aad_bits_ff + {56'd0, q_item.nbits};
                     emit_in     = 1'b0;
                  end
                  CMD_TEXT: begin
                     ctr_in       = ctr_ff + 32'd1;
                     aes_in       = {iv, ctr_ff + 32'd1} ^ rk_ff[0];
                     job_in       = JOB_TEXT;
                     text_bits_in = text_bits_ff + {56'd0, q_item.nbits};
                  end
                  CMD_FINISH: begin
                     x_in    = acc_ff ^ {aad_bits_ff, text_bits_ff};
                     emit_in = 1'b1;
                     tag_in  = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_KEYEXP: begin
            rk_we   = 1'b1;
            prev_in = key_new;
            if (aes_last) begin
               aes_in = rk_ff[0];
               job_in = JOB_HSUB;
               rnd_in = 4'd1;
            end else begin
               rnd_in = rnd_ff + 4'd1;
            end
         end
         ST_AES: begin
            aes_in = round_out;
            rnd_in = rnd_ff + 4'd1;
            if (aes_last) begin
               rnd_in = 4'd1;
               unique case (job_ff)
                  JOB_HSUB: begin
                     hsub_in = round_out;
                     aes_in  = {iv, 32'd1} ^ rk_ff[0];
                     job_in  = JOB_TMASK;
                  end
                  JOB_TMASK: begin
                     tmask_in = round_out;
                  end
                  JOB_TEXT: begin
                     ct_in   = ct_new;
                     x_in    = acc_ff ^ ct_new;
                     emit_in = 1'b1;
                     tag_in  = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_GHASH: begin
            gf_in   = gf_new;
            x_in    = {x_ff[119:0], 8'd0};
            gcnt_in = gcnt_ff + 4'd1;
            if (gf_last) begin
               acc_in        = gf_new.z;
               result.valid  = emit_ff;
               result.value  = tag_ff ? (gf_new.z ^ tmask_ff) : ct_ff;
               result.is_tag = tag_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= 128'd0;
         ctr_ff       <= 32'd0;
         aad_bits_ff  <= 64'd0;
         text_bits_ff <= 64'd0;
         emit_ff      <= 1'b0;
         tag_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         ctr_ff       <= ctr_in;
         aad_bits_ff  <= aad_bits_in;
         text_bits_ff <= text_bits_in;
         emit_ff      <= emit_in;
         tag_ff       <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      rnd_ff   <= rnd_in;
      gcnt_ff  <= gcnt_in;
      prev_ff  <= prev_in;
      aes_ff   <= aes_in;
      hsub_ff  <= hsub_in;
      tmask_ff <= tmask_in;
      x_ff     <= x_in;
      gf_ff    <= gf_in;
      ct_ff    <= ct_in;
      data_ff  <= data_in;
      mask_ff  <= mask_in;
      if (rk_we) begin
         rk_ff[rk_waddr] <= rk_wdata;
      end
   end

endmodule

### rtl/aes128_gcm_encrypt_unit.sv
`timescale 1ns / 1ps

// AES-128-GCM encrypt engine.
// Request channel (req_*): cmd start / AAD / plaintext / finish, a 128-bit
// block and a byte count (1..16, larger counts taken as 16, rest zeroed).
// Response channel (rsp_*): one response per plaintext (ciphertext, is_tag=0)
// and per finish (tag, is_tag=1); start and AAD produce none.
// Key and IV sit in csr_* registers; write them only while the engine is idle.
// Key changes take effect at the next start, IV is used live.
// A two-entry queue decouples request intake from the engine, so requests are
// taken while the engine works. The engine runs one request at a time:
//   start     : key schedule, AES of the zero block (H), AES of counter 1 (tag mask)
//   AAD/finish: one GHASH multiply (8 bits of the multiply per cycle)
//   plaintext : 10 AES rounds on the next counter block, then one GHASH multiply
// The engine has one AES round unit and one 8-bit GHASH multiplier step.
// The response appears in the output register in the cycle after GHASH ends.
// A stalled response holds; the engine takes no new request of any kind
// until the output register is free.
// Reset (synchronous) clears the queue, engine state, hash and counters.

module aes128_gcm_encrypt_unit import gcmenc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_wr_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [1:0]    req_cmd,
   input  logic [63:0]   req_data_hi,
   input  logic [63:0]   req_data_lo,
   input  logic [4:0]    req_valid_bytes,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [63:0]   rsp_out_hi,
   output logic [63:0]   rsp_out_lo,
   output logic          rsp_is_tag
);

   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff;
   logic [31:0]  iv_lo_ff;
   logic         q_valid;
   item_type     q_item;
   logic         q_pop;
   result_type   result;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [127:0] rsp_value_ff;
   logic         rsp_is_tag_ff;

   // config registers; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= 64'd0;
         key_lo_ff <= 64'd0;
         iv_hi_ff  <= 64'd0;
         iv_lo_ff  <= 32'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KEY_HI: key_hi_ff <= csr_wr_data;
            CSR_KEY_LO: key_lo_ff <= csr_wr_data;
            CSR_IV_HI:  iv_hi_ff  <= csr_wr_data;
            CSR_IV_LO:  iv_lo_ff  <= csr_wr_data[31:0];
            default: ;
         endcase
      end
   end

   gcmenc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_data_hi     (req_data_hi),
      .req_data_lo     (req_data_lo),
      .req_valid_bytes (req_valid_bytes),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop)
   );

   gcmenc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop),
      .key      ({key_hi_ff, key_lo_ff}),
      .iv       ({iv_hi_ff, iv_lo_ff}),
      .out_busy (rsp_valid_ff),
      .result   (result)
   );

   // output register
   always_comb begin
      if (result.valid) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_value_ff  <= result.value;
         rsp_is_tag_ff <= result.is_tag;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_hi = rsp_value_ff[127:64];
   assign rsp_out_lo = rsp_value_ff[63:0];
   assign rsp_is_tag = rsp_is_tag_ff;

endmodule
